### design/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types, constants and helpers for the NFA subset simulator.
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int NUM_STATES  = 16;
    localparam int SYMBOL_BITS = 8;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int ADDR_W      = STATE_W + SYMBOL_BITS;
    localparam int STORE_DEPTH = NUM_STATES << SYMBOL_BITS;

    // fixed field widths of the stream payload
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 4;
    localparam int SYM_W   = 8;
    localparam int MASK_W  = 16;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [MASK_W-1:0] STATE_MASK = MASK_W'((64'd1 << NUM_STATES) - 64'd1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SYMBOL = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_MASK  = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] state_index;
        logic [SYM_W-1:0]   symbol;
        logic [MASK_W-1:0]  next_mask;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] start_state;
        logic [MASK_W-1:0]  final_mask;
    } cfg_t;

    typedef struct packed {
        logic               dead;
        logic               accepted;
        logic [MASK_W-1:0]  reached_mask;
    } result_t;

    // index of the lowest set bit (0 when none is set)
    function automatic logic [STATE_W-1:0] lowest_index(input logic [MASK_W-1:0] m);
        logic [STATE_W-1:0] idx;
        idx = '0;
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = STATE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### design/nfa_subset_simulator_unit.sv
// ----------------------------------------------------------------------------
// nfa_subset_simulator_unit
// Bit-vector NFA simulator with a stream input, stream result and a
// configuration write port.
// ----------------------------------------------------------------------------
// After reset the unit clears all 4096 entries of the transition memory (one
// entry a cycle) and holds s_tready low meanwhile; configuration writes are
// taken at any time. A load writes its entry when it is accepted; a start emits
// a result. A symbol reads one memory row per active state through the single
// read port. A finished result sits in an output register so the next transfer
// can be taken while m_tvalid waits on m_tready.
// ----------------------------------------------------------------------------
module nfa_subset_simulator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] state_index, [11:4] symbol, [27:12] next_mask, [31:28] zero
    input  logic [nss_pkg::S_TDATA_W-1:0]       s_tdata,
    // [1:0] command
    input  logic [nss_pkg::CMD_W-1:0]           s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] reached_mask, [16] accepted, [17] dead, [23:18] zero
    output logic [nss_pkg::M_TDATA_W-1:0]       m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import nss_pkg::*;

    item_t   item;
    cfg_t    cfg_reg;
    result_t res;
    logic    res_valid, res_ready;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_res_reg;

    assign item.command     = s_tuser;
    assign item.state_index = s_tdata[3:0];
    assign item.symbol      = s_tdata[11:4];
    assign item.next_mask   = s_tdata[27:12];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_STATE: cfg_reg.start_state <= cfg_data[INDEX_W-1:0];
                CFG_FINAL_MASK:  cfg_reg.final_mask  <= cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nss_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: refill when empty or draining this cycle
    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = (res_valid && res_ready) || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - MASK_W - 2)'(0), m_res_reg};

endmodule

### design/nss_ram.sv
// ----------------------------------------------------------------------------
// nss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/nss_core.sv
// ----------------------------------------------------------------------------
// nss_core
// Sequencer around the transition memory: clearing pass, entry loads, and
// the per-symbol scan over the active states.
// ----------------------------------------------------------------------------
module nss_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  nss_pkg::item_t  in_item,
    input  nss_pkg::cfg_t   cfg,
    output logic            res_valid,
    input  logic            res_ready,
    output nss_pkg::result_t res
);
    import nss_pkg::*;

    typedef enum logic [1:0] {CLEAR, IDLE, SCAN, EMIT} state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [MASK_W-1:0]       active_reg, active_next;
    logic [MASK_W-1:0]       rem_reg, rem_next;
    logic [MASK_W-1:0]       acc_reg, acc_next;
    logic [MASK_W-1:0]       res_mask_reg, res_mask_next;
    logic [SYMBOL_BITS-1:0]  sym_reg, sym_next;
    logic                    pend_reg, pend_next;

    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [MASK_W-1:0]       ram_wdata, ram_rdata;
    logic                    accept;
    logic [MASK_W-1:0]       acc_sum;

    nss_ram #(
        .WIDTH (MASK_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;
    assign acc_sum  = acc_reg | (pend_reg ? ram_rdata : '0);

    assign res_valid        = (state_reg == EMIT);
    assign res.reached_mask = res_mask_reg;
    assign res.accepted     = |(res_mask_reg & cfg.final_mask);
    assign res.dead         = (res_mask_reg == '0);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        active_next   = active_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        res_mask_next = res_mask_reg;
        sym_next      = sym_reg;
        pend_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {in_item.state_index[STATE_W-1:0], in_item.symbol[SYMBOL_BITS-1:0]};
        ram_wdata     = in_item.next_mask & STATE_MASK;
        ram_re        = 1'b0;
        ram_raddr     = {lowest_index(rem_reg), sym_reg};

        case (state_reg)
            CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (accept) begin
                    case (in_item.command)
                        CMD_LOAD: begin
                            ram_we = (int'(in_item.state_index) < NUM_STATES);
                        end
                        CMD_START: begin
                            if (int'(cfg.start_state) < NUM_STATES) begin
                                active_next = MASK_W'(1) << cfg.start_state;
                            end else begin
                                active_next = '0;
                            end
                            res_mask_next = active_next;
                            state_next    = EMIT;
                        end
                        CMD_SYMBOL: begin
                            rem_next   = active_reg;
                            acc_next   = '0;
                            sym_next   = in_item.symbol[SYMBOL_BITS-1:0];
                            state_next = SCAN;
                        end
                        default: begin
                            // unused command: dropped without a result
                        end
                    endcase
                end
            end
            SCAN: begin
                acc_next = acc_sum;
                if (rem_reg != '0) begin
                    ram_re    = 1'b1;
                    rem_next  = rem_reg & (rem_reg - 1'b1);
                    pend_next = 1'b1;
                end else begin
                    // last row (if any) lands this cycle
                    active_next   = acc_sum;
                    res_mask_next = acc_sum;
                    state_next    = EMIT;
                end
            end
            EMIT: begin
                if (res_ready) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CLEAR;
            clr_addr_reg <= '0;
            active_reg   <= '0;
            rem_reg      <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            active_reg   <= active_next;
            rem_reg      <= rem_next;
            pend_reg     <= pend_next;
        end
        acc_reg      <= acc_next;
        res_mask_reg <= res_mask_next;
        sym_reg      <= sym_next;
    end

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("transition memory written and read in the same cycle");

    a_pend_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg == SCAN))
        else $error("read data pending outside a scan");

    a_symbol_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_item.command == CMD_SYMBOL) |=> (state_reg == SCAN))
        else $error("symbol transfer did not start a scan");

    a_rem_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SCAN) |-> ((rem_reg & ~active_reg) == '0))
        else $error("scan visits a state outside the active set");

endmodule

### tb/nfa_subset_simulator_unit_test.sv
// ----------------------------------------------------------------------------
// nfa_subset_simulator_unit_test
// Self-checking bench for the NFA subset simulator. A directed burst hits the
// corner cases, then random phases build a small automaton over a few symbols
// and run words through it. A scoreboard follows the automaton, the transition
// table and both registers, and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module nfa_subset_simulator_unit_test;
    import nss_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 155;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    nfa_subset_simulator_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scoreboard copy of the automaton
    logic [MASK_W-1:0]  move_table [STORE_DEPTH];
    logic [MASK_W-1:0]  live_states = '0;
    logic [INDEX_W-1:0] start_sel = '0;
    logic [MASK_W-1:0]  accept_mask = '0;

    item_t   word_feed [$];
    result_t pending_reports [$];

    item_t   feed_head;
    item_t   taken_item;
    result_t got_report;
    result_t want_report;
    logic    s_fire = 1'b0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit hold_used = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void post_report();
        result_t r;
        r.reached_mask = live_states & STATE_MASK;
        r.accepted     = |(r.reached_mask & accept_mask);
        r.dead         = (r.reached_mask == '0);
        pending_reports = {pending_reports, r};
    endfunction

    function automatic void advance_nfa(input item_t it);
        logic [MASK_W-1:0] reach;
        reach = '0;
        case (it.command)
            CMD_LOAD: begin
                if (it.state_index < NUM_STATES) begin
                    move_table[{it.state_index, it.symbol}] = it.next_mask & STATE_MASK;
                end
            end
            CMD_START: begin
                live_states = (start_sel < NUM_STATES) ? (MASK_W'(1) << start_sel) : '0;
                post_report();
            end
            CMD_SYMBOL: begin
                for (int s = 0; s < NUM_STATES; s++) begin
                    if (live_states[s]) begin
                        reach |= move_table[{STATE_W'(s), it.symbol}];
                    end
                end
                live_states = reach & STATE_MASK;
                post_report();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (word_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                feed_head = word_feed.pop_front();
                s_tdata  <= {4'b0, feed_head.next_mask, feed_head.symbol, feed_head.state_index};
                s_tuser  <= feed_head.command;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long back-pressure stretch, armed once
    always @(negedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor and scoreboard
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            taken_item.command     = s_tuser;
            taken_item.state_index = s_tdata[3:0];
            taken_item.symbol      = s_tdata[11:4];
            taken_item.next_mask   = s_tdata[27:12];
            advance_nfa(taken_item);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_report.reached_mask = m_tdata[15:0];
            got_report.accepted     = m_tdata[16];
            got_report.dead         = m_tdata[17];
            if (pending_reports.size() == 0) begin
                $error("result transfer with none expected: %h", m_tdata);
                fail_count++;
            end else begin
                want_report = pending_reports.pop_front();
                if (got_report.reached_mask !== want_report.reached_mask) begin
                    $error("reached_mask: expected %h, got %h",
                           want_report.reached_mask, got_report.reached_mask);
                    fail_count++;
                end
                if (got_report.accepted !== want_report.accepted) begin
                    $error("accepted: expected %b, got %b",
                           want_report.accepted, got_report.accepted);
                    fail_count++;
                end
                if (got_report.dead !== want_report.dead) begin
                    $error("dead: expected %b, got %b", want_report.dead, got_report.dead);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void add(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] msk);
        item_t it;
        it.command     = cmd;
        it.state_index = idx;
        it.symbol      = sym;
        it.next_mask   = msk;
        word_feed = {word_feed, it};
    endfunction

    // mostly one or two successors, so active sets stay interesting
    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(9))
            0: return '0;
            1: return MASK_W'($urandom);
            default: return (MASK_W'(1) << $urandom_range(15)) |
                            (MASK_W'(1) << $urandom_range(15));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_START_STATE: start_sel = val[INDEX_W-1:0];
            CFG_FINAL_MASK:  accept_mask = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (word_feed.size() != 0 || s_tvalid || pending_reports.size() != 0);
        // loads give no result and may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random_phase(input int target);
        logic [SYM_W-1:0] alpha [4];
        int made;
        int wlen;
        made = 0;
        foreach (alpha[k]) alpha[k] = SYM_W'($urandom_range(255));
        for (int s = 0; s < NUM_STATES; s++) begin
            foreach (alpha[k]) begin
                if ($urandom_range(99) < 60) begin
                    add(CMD_LOAD, INDEX_W'(s), alpha[k], pick_mask());
                    made++;
                end
            end
        end
        while (made < target) begin
            case ($urandom_range(19))
                0: add(CMD_UNUSED, INDEX_W'($urandom), SYM_W'($urandom), MASK_W'($urandom));
                1: begin
                    add(CMD_LOAD, INDEX_W'($urandom), alpha[2'($urandom_range(3))],
                        pick_mask());
                    made++;
                end
                2: begin
                    // stray symbol, carries on from whatever set is active
                    add(CMD_SYMBOL, INDEX_W'($urandom), SYM_W'($urandom), MASK_W'($urandom));
                    made++;
                end
                default: begin
                    add(CMD_START, INDEX_W'($urandom), SYM_W'($urandom), MASK_W'($urandom));
                    made++;
                    wlen = $urandom_range(8);
                    repeat (wlen) begin
                        add(CMD_SYMBOL, INDEX_W'($urandom), alpha[2'($urandom_range(3))],
                            MASK_W'($urandom));
                        made++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        foreach (move_table[i]) move_table[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed burst; upper data bits of start_state must be dropped
        tx_idle_pct = 37;
        rx_idle_pct = 75;
        write_reg(CFG_START_STATE, 16'hFFF0);
        write_reg(CFG_FINAL_MASK, 16'h8001);
        add(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);     // no start yet: dead
        add(CMD_UNUSED, 4'hF, 8'hFF, 16'hFFFF);
        add(CMD_LOAD,   4'h0, 8'h00, 16'hFFFF);
        add(CMD_LOAD,   4'hF, 8'hFF, 16'h8001);
        add(CMD_LOAD,   4'h0, 8'hFF, 16'h0000);
        add(CMD_LOAD,   4'h7, 8'hAA, 16'h0080);
        add(CMD_START,  4'hF, 8'hFF, 16'hFFFF);
        add(CMD_SYMBOL, 4'hF, 8'h00, 16'hFFFF);     // fans out to every state
        add(CMD_SYMBOL, 4'h0, 8'hFF, 16'h0000);
        add(CMD_SYMBOL, 4'h0, 8'h55, 16'h0000);     // no entries: dies
        add(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);
        add(CMD_START,  4'h0, 8'h00, 16'h0000);
        add(CMD_SYMBOL, 4'h0, 8'hFF, 16'h0000);
        add(CMD_START,  4'h0, 8'h00, 16'h0000);
        add(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);
        add(CMD_SYMBOL, 4'h0, 8'hAA, 16'h0000);     // only the self loop survives
        add(CMD_SYMBOL, 4'h0, 8'hAA, 16'h0000);
        add(CMD_UNUSED, 4'h0, 8'h00, 16'h0000);
        add(CMD_LOAD,   4'h0, 8'h00, 16'h0000);     // overwrite an entry
        add(CMD_START,  4'h0, 8'h00, 16'h0000);
        add(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);
        wait_drained();

        for (int p = 1; p <= 6; p++) begin
            tx_idle_pct = (p <= 2) ? 37 : (p <= 4) ? 75 : 0;
            rx_idle_pct = (p <= 2) ? 75 : (p <= 4) ? 37 : 0;
            case (p)
                1: begin
                    write_reg(CFG_START_STATE, 16'h000F);
                    write_reg(CFG_FINAL_MASK, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_START_STATE, 16'hABC0);
                    write_reg(CFG_FINAL_MASK, 16'h0000);
                end
                4: begin
                    write_reg(CFG_START_STATE, 16'h5A5F);
                    write_reg(CFG_FINAL_MASK, CFG_DATA_W'($urandom));
                end
                5: begin
                    write_reg(CFG_START_STATE, CFG_DATA_W'($urandom));
                    write_reg(CFG_FINAL_MASK, 16'hFFFF);
                end
                default: begin
                    write_reg(CFG_START_STATE, CFG_DATA_W'($urandom));
                    write_reg(CFG_FINAL_MASK, CFG_DATA_W'($urandom));
                end
            endcase
            queue_random_phase(PHASE_ITEMS);
            if (p == 5) hold_go = 1'b1;
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
